// File: hdl/tnop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tnop_pkg - shared types and constants of the telnet option parser
// Telnet command bytes, result channel codes, the command word that passes
// from the parser front to the reply back end, and the terminal-type reply.
// ============================================================================
package tnop_pkg;

    // Telnet command bytes
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SE   = 8'd240;
    localparam logic [7:0] TN_EOR  = 8'd239;

    // Option codes
    localparam logic [7:0] OPT_TRANSMIT_BIN = 8'd0;
    localparam logic [7:0] OPT_TERM_TYPE    = 8'd24;
    localparam logic [7:0] OPT_EOR          = 8'd25;

    // Stored verb, relative to WILL
    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_WONT = 2'd1;
    localparam logic [1:0] VERB_DO   = 2'd2;
    localparam logic [1:0] VERB_DONT = 2'd3;

    // Result channels
    localparam logic [1:0] CH_DATA = 2'd0;
    localparam logic [1:0] CH_EOR  = 2'd1;
    localparam logic [1:0] CH_TX   = 2'd2;

    // Terminal-type reply
    localparam int         TT_LEN  = 18;
    localparam int         CNT_W   = 5;
    localparam logic [CNT_W-1:0] TT_LAST  = CNT_W'(TT_LEN - 1);
    localparam logic [CNT_W-1:0] NEG_LAST = CNT_W'(2);

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_EOR   = 2'd1,
        CMD_NEG   = 2'd2,
        CMD_TTYPE = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] value;   // data byte or negotiated option
        logic [7:0] verb;    // answer verb for a negotiation
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Byte idx of the terminal-type subnegotiation reply
    function automatic logic [7:0] tt_byte(input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'd255;
            5'd1:    b = 8'd250;
            5'd2:    b = 8'd24;
            5'd3:    b = 8'd0;
            5'd4:    b = 8'd73;
            5'd5:    b = 8'd66;
            5'd6:    b = 8'd77;
            5'd7:    b = 8'd45;
            5'd8:    b = 8'd51;
            5'd9:    b = 8'd50;
            5'd10:   b = 8'd55;
            5'd11:   b = 8'd56;
            5'd12:   b = 8'd45;
            5'd13:   b = 8'd50;
            5'd14:   b = 8'd45;
            5'd15:   b = 8'd69;
            5'd16:   b = 8'd255;
            5'd17:   b = 8'd240;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: hdl/tnop_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tnop_front - receive parser
// Accept received bytes, track the telnet command state and turn each byte
// that needs an answer or a data result into one command word.
// ============================================================================
module tnop_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          rx_byte,
    input  wire tnop_pkg::q_status_t q_status,
    output logic                     push,
    output tnop_pkg::cmd_t           cmd
);

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_IAC     = 3'd1,
        ST_VERB    = 3'd2,
        ST_SUBOPT  = 3'd3,
        ST_SUBDATA = 3'd4,
        ST_SUBIAC  = 3'd5
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] verb_reg, verb_next;
    logic       tt_reg, tt_next;
    logic       accept;
    logic       want_push;
    logic       supported;
    logic [7:0] answer;
    logic [7:0] verb_diff;

    assign in_stall  = q_status.full;
    assign accept    = in_valid && !q_status.full;
    assign push      = accept && want_push;
    assign verb_diff = rx_byte - tnop_pkg::TN_WILL;
    assign supported = (rx_byte == tnop_pkg::OPT_TRANSMIT_BIN)
                    || (rx_byte == tnop_pkg::OPT_TERM_TYPE)
                    || (rx_byte == tnop_pkg::OPT_EOR);

    always_comb
    begin
        unique case (verb_reg)
            tnop_pkg::VERB_WILL: answer = supported ? tnop_pkg::TN_DO : tnop_pkg::TN_DONT;
            tnop_pkg::VERB_WONT: answer = tnop_pkg::TN_DONT;
            tnop_pkg::VERB_DO:   answer = supported ? tnop_pkg::TN_WILL : tnop_pkg::TN_WONT;
            default:             answer = tnop_pkg::TN_WONT;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        verb_next  = verb_reg;
        tt_next    = tt_reg;
        want_push  = 1'b0;
        cmd.kind   = tnop_pkg::CMD_DATA;
        cmd.value  = rx_byte;
        cmd.verb   = answer;
        unique case (state_reg)
            ST_IAC:
            begin
                state_next = ST_DATA;
                if (rx_byte == tnop_pkg::TN_IAC)
                begin
                    want_push = 1'b1;
                end
                else if (rx_byte == tnop_pkg::TN_EOR)
                begin
                    want_push = 1'b1;
                    cmd.kind  = tnop_pkg::CMD_EOR;
                end
                else if (rx_byte == tnop_pkg::TN_SB)
                begin
                    state_next = ST_SUBOPT;
                end
                else if (rx_byte >= tnop_pkg::TN_WILL && rx_byte <= tnop_pkg::TN_DONT)
                begin
                    verb_next  = verb_diff[1:0];
                    state_next = ST_VERB;
                end
            end
            ST_VERB:
            begin
                want_push  = 1'b1;
                cmd.kind   = tnop_pkg::CMD_NEG;
                state_next = ST_DATA;
            end
            ST_SUBOPT:
            begin
                tt_next    = (rx_byte == tnop_pkg::OPT_TERM_TYPE);
                state_next = ST_SUBDATA;
            end
            ST_SUBDATA:
            begin
                if (rx_byte == tnop_pkg::TN_IAC)
                begin
                    state_next = ST_SUBIAC;
                end
            end
            ST_SUBIAC:
            begin
                if (rx_byte == tnop_pkg::TN_SE)
                begin
                    want_push  = tt_reg;
                    cmd.kind   = tnop_pkg::CMD_TTYPE;
                    state_next = ST_DATA;
                end
                else
                begin
                    state_next = ST_SUBDATA;
                end
            end
            default:
            begin
                // data state
                if (rx_byte == tnop_pkg::TN_IAC)
                begin
                    state_next = ST_IAC;
                end
                else
                begin
                    want_push  = 1'b1;
                    state_next = ST_DATA;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DATA;
            verb_reg  <= 2'd0;
            tt_reg    <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            verb_reg  <= verb_next;
            tt_reg    <= tt_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/tnop_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tnop_queue - command queue
// Small register FIFO that decouples the parser from the reply back end.
// ============================================================================
module tnop_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tnop_pkg::cmd_t     wr_cmd,
    input  wire logic               pop,
    output tnop_pkg::cmd_t          head,
    output tnop_pkg::q_status_t     status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tnop_pkg::cmd_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule
`default_nettype wire

// File: hdl/tnop_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tnop_back - reply back end
// Expand the command at the queue head into result words, one per cycle while
// the output is not stalled, into a registered output stage.
// ============================================================================
module tnop_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tnop_pkg::cmd_t      head,
    input  wire tnop_pkg::q_status_t q_status,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               out_channel,
    output logic [7:0]               out_byte,
    output logic                     out_last
);

    logic [tnop_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic       out_valid_reg;
    logic [1:0] channel_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       advance;
    logic [1:0] word_channel;
    logic [7:0] word_byte;
    logic       word_last;

    assign advance = !q_status.empty && (!out_valid_reg || !out_stall);
    assign pop     = advance && word_last;

    always_comb
    begin
        unique case (head.kind)
            tnop_pkg::CMD_DATA:
            begin
                word_channel = tnop_pkg::CH_DATA;
                word_byte    = head.value;
                word_last    = 1'b1;
            end
            tnop_pkg::CMD_EOR:
            begin
                word_channel = tnop_pkg::CH_EOR;
                word_byte    = 8'd0;
                word_last    = 1'b1;
            end
            tnop_pkg::CMD_NEG:
            begin
                word_channel = tnop_pkg::CH_TX;
                word_last    = (cnt_reg == tnop_pkg::NEG_LAST);
                if (cnt_reg == '0)
                begin
                    word_byte = tnop_pkg::TN_IAC;
                end
                else if (word_last)
                begin
                    word_byte = head.value;
                end
                else
                begin
                    word_byte = head.verb;
                end
            end
            default:
            begin
                word_channel = tnop_pkg::CH_TX;
                word_byte    = tnop_pkg::tt_byte(cnt_reg);
                word_last    = (cnt_reg == tnop_pkg::TT_LAST);
            end
        endcase
    end

    // step through the words of a multi-word reply, restart on the last one
    assign cnt_next = word_last ? '0 : cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            channel_reg <= word_channel;
            byte_reg    <= word_byte;
            last_reg    <= word_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = channel_reg;
    assign out_byte    = byte_reg;
    assign out_last    = last_reg;

endmodule
`default_nettype wire

// File: hdl/telnet_receive_option_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// telnet_receive_option_parser - telnet receive-side option parser
// Separate record data from telnet commands, mark ends of record, answer
// option negotiation and reply to a terminal-type subnegotiation.
// ============================================================================
//
//  channel  handshake            payload                         direction
//  -------  -------------------  ------------------------------  ---------
//  input    in_valid / in_stall  rx_byte[7:0]                    into block
//  output   out_valid/out_stall  out_channel[1:0] out_byte[7:0]  out of block
//                                out_last
//
//  A received byte is taken by the parser front, and its command word
//  enters the queue at the edge that accepts the byte. The back end drains
//  one result word per cycle while the output is not stalled: a data byte
//  or end-of-record marker gives one word, a negotiation answer three, the
//  terminal-type reply eighteen. The back end's single output port sets the
//  sustained rate, and a queue of QUEUE_DEPTH commands absorbs the bursts.
//  Reset clears the parser state and empties the queue; no clearing pass is
//  needed. in_stall rises only while the queue is full.
//
module telnet_receive_option_parser
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      out_channel,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    tnop_pkg::cmd_t      push_cmd;
    tnop_pkg::cmd_t      head_cmd;
    tnop_pkg::q_status_t q_status;
    logic                push;
    logic                pop;

    // Front: parse each accepted byte, push a command when it needs results
    tnop_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Queue: hold pending commands so each side can stall on its own
    tnop_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (push_cmd),
        .pop    (pop),
        .head   (head_cmd),
        .status (q_status)
    );

    // Back: expand the head command into result words, pop on its last word
    tnop_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .out_byte    (out_byte),
        .out_last    (out_last)
    );

    // A queue cannot be full and empty at once
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // The back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // A command is pushed only for an accepted byte
    a_push_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (in_valid && !in_stall))
        else $error("push without accepted byte");

    // An end-of-record marker is a single zero word
    a_eor_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_channel == tnop_pkg::CH_EOR) |-> (out_last && out_byte == 8'd0))
        else $error("malformed end-of-record word");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - self-checking bench for telnet_receive_option_parser
// Feeds received telnet bytes through a valid/stall channel, predicts every
// output word (record data, end-of-record, transmit bytes) with an
// independent parser model and compares each accepted output word in order.
// ============================================================================
module testbench;

    localparam int LONG_HOLD  = 200;   // cycles the receiver holds off once
    localparam int TAIL_WAIT  = 20;    // settle time after the last word
    localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before timeout
    localparam int RAND_ITEMS = 345;

    // Parser states of the predictor
    typedef enum logic [2:0] {
        PS_DATA,
        PS_IAC,
        PS_VERB,
        PS_SUBOPT,
        PS_SUBDATA,
        PS_SUBIAC
    } parse_state_t;

    typedef struct {
        logic [1:0] channel;
        logic [7:0] value;
        logic       last;
    } out_word_t;

    // ------------------------------------------------------------------------
    // Predict the words caused by each received byte and match them in order
    // ------------------------------------------------------------------------
    class telnet_reply_board;
        localparam logic [7:0] TT_IS = 8'd0;

        out_word_t    expected_words[$];
        logic [7:0]   ttype_reply[$];
        parse_state_t state;
        logic [1:0]   verb;
        logic         sub_ttype;
        int           errors;
        int           reported;
        int           rx_count;
        int           word_count;
        int           channel_count[3];
        int           ttype_replies;
        int           answers;

        function new();
            state         = PS_DATA;
            verb          = tnop_pkg::VERB_WILL;
            sub_ttype     = 1'b0;
            errors        = 0;
            reported      = 0;
            rx_count      = 0;
            word_count    = 0;
            ttype_replies = 0;
            answers       = 0;
            foreach (channel_count[i])
                channel_count[i] = 0;
            // IAC SB TTYPE IS, terminal model name in ASCII, IAC SE
            ttype_reply = '{tnop_pkg::TN_IAC, tnop_pkg::TN_SB, tnop_pkg::OPT_TERM_TYPE, TT_IS,
                            8'd73, 8'd66, 8'd77, 8'd45, 8'd51, 8'd50,
                            8'd55, 8'd56, 8'd45, 8'd50, 8'd45, 8'd69,
                            tnop_pkg::TN_IAC, tnop_pkg::TN_SE};
        endfunction

        function void add_word(logic [1:0] ch, logic [7:0] v);
            out_word_t w;
            w.channel = ch;
            w.value   = v;
            w.last    = 1'b0;
            expected_words.push_back(w);
        endfunction

        function void take_rx_byte(logic [7:0] b);
            int         before_n;
            logic [7:0] rel;
            logic [7:0] answer;
            logic       supported;
            before_n  = expected_words.size();
            rx_count++;
            supported = (b == tnop_pkg::OPT_TRANSMIT_BIN) || (b == tnop_pkg::OPT_TERM_TYPE)
                     || (b == tnop_pkg::OPT_EOR);
            case (state)
                PS_IAC:
                begin
                    // Any command not listed below is dropped silently
                    state = PS_DATA;
                    if (b == tnop_pkg::TN_IAC)
                        add_word(tnop_pkg::CH_DATA, tnop_pkg::TN_IAC);
                    else if (b == tnop_pkg::TN_EOR)
                        add_word(tnop_pkg::CH_EOR, 8'd0);
                    else if (b == tnop_pkg::TN_SB)
                        state = PS_SUBOPT;
                    else if (b >= tnop_pkg::TN_WILL && b <= tnop_pkg::TN_DONT)
                    begin
                        rel   = b - tnop_pkg::TN_WILL;
                        verb  = rel[1:0];
                        state = PS_VERB;
                    end
                end
                PS_VERB:
                begin
                    case (verb)
                        tnop_pkg::VERB_DO:
                            answer = supported ? tnop_pkg::TN_WILL : tnop_pkg::TN_WONT;
                        tnop_pkg::VERB_WILL:
                            answer = supported ? tnop_pkg::TN_DO : tnop_pkg::TN_DONT;
                        tnop_pkg::VERB_DONT:
                            answer = tnop_pkg::TN_WONT;
                        default:
                            answer = tnop_pkg::TN_DONT;
                    endcase
                    add_word(tnop_pkg::CH_TX, tnop_pkg::TN_IAC);
                    add_word(tnop_pkg::CH_TX, answer);
                    add_word(tnop_pkg::CH_TX, b);
                    answers++;
                    state = PS_DATA;
                end
                PS_SUBOPT:
                begin
                    sub_ttype = (b == tnop_pkg::OPT_TERM_TYPE);
                    state     = PS_SUBDATA;
                end
                PS_SUBDATA:
                begin
                    if (b == tnop_pkg::TN_IAC)
                        state = PS_SUBIAC;
                end
                PS_SUBIAC:
                begin
                    if (b == tnop_pkg::TN_SE)
                    begin
                        if (sub_ttype)
                        begin
                            foreach (ttype_reply[i])
                                add_word(tnop_pkg::CH_TX, ttype_reply[i]);
                            ttype_replies++;
                        end
                        state = PS_DATA;
                    end
                    else
                        state = PS_SUBDATA;
                end
                default:
                begin
                    if (b == tnop_pkg::TN_IAC)
                        state = PS_IAC;
                    else
                        add_word(tnop_pkg::CH_DATA, b);
                end
            endcase
            if (expected_words.size() > before_n)
                expected_words[expected_words.size() - 1].last = 1'b1;
        endfunction

        function void note_error(string msg);
            errors++;
            if (reported < 10)
            begin
                reported++;
                $display("ERROR @%0t: %s", $realtime, msg);
            end
        endfunction

        function void match_output(logic [1:0] ch, logic [7:0] v, logic last);
            out_word_t w;
            word_count++;
            if (ch == tnop_pkg::CH_DATA || ch == tnop_pkg::CH_EOR || ch == tnop_pkg::CH_TX)
                channel_count[int'(ch)]++;
            if (expected_words.size() == 0)
            begin
                note_error($sformatf("unexpected word ch=%0d byte=%0d last=%0d",
                                     ch, v, last));
                return;
            end
            w = expected_words.pop_front();
            if (w.channel !== ch || w.value !== v || w.last !== last)
                note_error($sformatf(
                    "word %0d: expected ch=%0d byte=%0d last=%0d, got ch=%0d byte=%0d last=%0d",
                    word_count, w.channel, w.value, w.last, ch, v, last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] rx_byte     = 8'd0;
    logic       out_stall   = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] out_channel;
    logic [7:0] out_byte;
    logic       out_last;

    telnet_reply_board board = new();

    bit idle_on       = 1'b1;  // both sides insert random gaps when set
    int hold_seq      = 0;     // bump to ask the receiver for one long hold
    int results_taken = 0;     // output handshakes seen by the monitor
    int idle_cycles   = 0;

    always #10 clk = ~clk;

    telnet_receive_option_parser dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .out_byte    (out_byte),
        .out_last    (out_last)
    );

    // ------------------------------------------------------------------------
    // Monitor: take both handshakes at the rising edge, in one process, so
    // the prediction always lands before a same-cycle output is matched.
    // Also run the watchdog here: end the run after too long without traffic.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : handshake_monitor
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.take_rx_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                board.match_output(out_channel, out_byte, out_last);
                results_taken++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles, %0d words outstanding",
                         IDLE_LIMIT, board.expected_words.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: after each accepted word draw a random stall length; on
    // request hold off for one long stretch so the block backs up and stalls
    // its input. Count the stretch here, independent of the sender.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : result_receiver
        int stall_left;
        int hold_seen;
        int taken_seen;
        if (!rst_n)
        begin
            stall_left = 0;
            hold_seen  = 0;
            taken_seen = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_seq != hold_seen)
            begin
                hold_seen  = hold_seq;
                taken_seen = results_taken;
                stall_left = LONG_HOLD;
            end
            else if (results_taken != taken_seen)
            begin
                taken_seen = results_taken;
                stall_left = idle_on ? $urandom_range(0, 5) : 0;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Each is entered and left at a falling edge. A word that
    // was just accepted stays on the port until the next one replaces it, a random
    // gap or go_quiet drops valid, so valid is never lowered and raised in one step.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        int target;
        gap    = idle_on ? $urandom_range(0, 5) : 0;
        target = board.rx_count + 1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        // hold the word until the monitor has seen it accepted
        do
            @(negedge clk);
        while (board.rx_count != target);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
    endtask

    // Pause input until every predicted word has come out, then settle
    task automatic wait_drained();
        while (board.expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_negotiation(input logic [7:0] verb_byte, input logic [7:0] opt);
        send_byte(tnop_pkg::TN_IAC);
        send_byte(verb_byte);
        send_byte(opt);
    endtask

    // Subnegotiation with random payload; an IAC inside the payload is
    // followed by anything but SE so the block stays in the subnegotiation
    task automatic send_subneg(input logic [7:0] opt);
        int         n_payload;
        logic [7:0] b;
        logic [7:0] c;
        n_payload = $urandom_range(0, 4);
        send_byte(tnop_pkg::TN_IAC);
        send_byte(tnop_pkg::TN_SB);
        send_byte(opt);
        repeat (n_payload)
        begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
            if (b == tnop_pkg::TN_IAC)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == tnop_pkg::TN_SE)
                    c = tnop_pkg::TN_SB;
                send_byte(c);
            end
        end
        send_byte(tnop_pkg::TN_IAC);
        send_byte(tnop_pkg::TN_SE);
    endtask

    task automatic send_random_sequence();
        int         pick;
        logic [7:0] opt;
        logic [7:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_byte(8'($urandom_range(0, 254)));
        else if (pick < 38)
        begin
            // doubled IAC is a data byte of 255
            send_byte(tnop_pkg::TN_IAC);
            send_byte(tnop_pkg::TN_IAC);
        end
        else if (pick < 46)
        begin
            send_byte(tnop_pkg::TN_IAC);
            send_byte(tnop_pkg::TN_EOR);
        end
        else if (pick < 70)
        begin
            case ($urandom_range(0, 3))
                0:       opt = tnop_pkg::OPT_TRANSMIT_BIN;
                1:       opt = tnop_pkg::OPT_TERM_TYPE;
                2:       opt = tnop_pkg::OPT_EOR;
                default: opt = 8'($urandom_range(0, 255));
            endcase
            send_negotiation(tnop_pkg::TN_WILL + 8'($urandom_range(0, 3)), opt);
        end
        else if (pick < 80)
            send_subneg($urandom_range(0, 1) ? tnop_pkg::OPT_TERM_TYPE
                                             : 8'($urandom_range(0, 255)));
        else if (pick < 88)
        begin
            // a command the parser does not know is dropped
            cmd = 8'($urandom_range(0, 249));
            if (cmd == tnop_pkg::TN_EOR)
                cmd = tnop_pkg::TN_SE;
            send_byte(tnop_pkg::TN_IAC);
            send_byte(cmd);
        end
        else
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [7:0] directed[$];
        int         rand_start;
        bit         pressure_done;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes of plain data, escaped IAC, end of record, one of each
        // verb with supported and unsupported options, an unknown command
        // and a terminal-type subnegotiation with payload
        directed = '{8'd0, 8'd254, 8'd127,
                     tnop_pkg::TN_IAC, tnop_pkg::TN_IAC,
                     tnop_pkg::TN_IAC, tnop_pkg::TN_EOR,
                     tnop_pkg::TN_IAC, tnop_pkg::TN_DO, tnop_pkg::OPT_TRANSMIT_BIN,
                     tnop_pkg::TN_IAC, tnop_pkg::TN_WILL, tnop_pkg::OPT_EOR,
                     tnop_pkg::TN_IAC, tnop_pkg::TN_WONT, tnop_pkg::OPT_TERM_TYPE,
                     tnop_pkg::TN_IAC, tnop_pkg::TN_DONT, 8'd255,
                     tnop_pkg::TN_IAC, 8'd241,
                     tnop_pkg::TN_IAC, tnop_pkg::TN_SB, tnop_pkg::OPT_TERM_TYPE, 8'd1,
                     tnop_pkg::TN_IAC, tnop_pkg::TN_SE};
        foreach (directed[i])
            send_byte(directed[i]);
        go_quiet();
        wait_drained();

        rand_start    = board.rx_count;
        pressure_done = 1'b0;
        while (board.rx_count - rand_start < RAND_ITEMS)
        begin
            // every third stretch of 60 words runs with no gaps on either side
            idle_on = (((board.rx_count - rand_start) / 60) % 3) != 2;

            if (!pressure_done && board.rx_count - rand_start >= 150)
            begin
                // Drain, then hold the receiver off while the sender keeps
                // offering back-to-back words so the queue fills up
                pressure_done = 1'b1;
                go_quiet();
                wait_drained();
                idle_on = 1'b0;
                hold_seq++;
                repeat (12)
                    send_byte(8'($urandom_range(0, 254)));
                send_subneg(tnop_pkg::OPT_TERM_TYPE);
                send_negotiation(tnop_pkg::TN_DO, tnop_pkg::OPT_TERM_TYPE);
                repeat (8)
                    send_byte(8'($urandom_range(0, 254)));
                idle_on = 1'b1;
            end
            else
                send_random_sequence();
        end
        go_quiet();
        wait_drained();

        $display("Run covered %0d received bytes and %0d output words",
                 board.rx_count, board.word_count);
        $display("(data %0d, end of record %0d, transmit %0d), %0d answers, %0d tt replies.",
                 board.channel_count[0], board.channel_count[1], board.channel_count[2],
                 board.answers, board.ttype_replies);
        if (board.errors == 0 && board.expected_words.size() == 0)
            $display("Verification passed");
        else
        begin
            $display("Mismatches: %0d", board.errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
